/* hw/rtl/lqlu_pkg.sv */
// Package for the linear Q-learning update block: sizes, codes, control-word
// layout, microcode table and fixed-point helper functions.
// No dependencies.
`default_nettype none

package lqlu_pkg;

    localparam int BEHAVIOR_COUNT = 4;
    localparam int SLOT_COUNT     = BEHAVIOR_COUNT + 2;
    localparam int CNT_W          = $clog2(SLOT_COUNT);
    localparam int BEH_W          = 4;
    localparam int W_W            = 32;
    localparam int FEAT_W         = 16;
    localparam int COEF_W         = 16;
    localparam int REW_W          = 16;
    localparam int MUL_B_W        = 17;
    localparam int MUL_W          = W_W + MUL_B_W;
    localparam int ACC_W          = 52;
    localparam int ADDR_W         = 3;
    localparam int DATA_W         = 32;

    localparam logic [FEAT_W-1:0] ONE_Q15         = 16'h8000;
    localparam logic [COEF_W-1:0] LEARN_RATE_RST  = 16'd6554;
    localparam logic [COEF_W-1:0] DISCOUNT_RST    = 16'd58982;
    localparam logic signed [W_W-1:0] Q_MAX       = 32'sh7fff_ffff;
    localparam logic signed [W_W-1:0] Q_MIN       = 32'sh8000_0000;
    localparam logic [CNT_W-1:0] BEH_LAST         = CNT_W'(BEHAVIOR_COUNT - 1);
    localparam logic [CNT_W-1:0] SLOT_LAST        = CNT_W'(SLOT_COUNT - 1);
    localparam logic [CNT_W-1:0] SLOT_FEAT0       = CNT_W'(BEHAVIOR_COUNT);
    localparam logic [CNT_W-1:0] SLOT_FEAT1       = CNT_W'(BEHAVIOR_COUNT + 1);

    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_CHOOSE = 2'd1,
        REQ_LEARN  = 2'd2
    } req_type_t;

    typedef enum logic {
        CFG_LEARNING_RATE = 1'b0,
        CFG_GAMMA         = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_RD_F0,
        S_MUL_F0,
        S_MUL_F1,
        S_ACC_SUM,
        S_EVAL,
        S_CMP,
        S_COMMIT,
        S_GAMMA,
        S_ACC_G,
        S_ERR,
        S_ALPHA,
        S_DELTA,
        S_SNAP_MUL,
        S_W_UPD,
        S_DONE
    } step_t;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_FEAT0,
        RD_FEAT1,
        RD_CNT,
        RD_CNT_INC
    } rd_sel_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_WF0,
        MUL_WF1,
        MUL_GAMMA,
        MUL_ALPHA,
        MUL_SNAP
    } mul_sel_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACC_LOAD,
        OP_ACC_ADD,
        OP_Q_EVAL,
        OP_Q_CMP,
        OP_COMMIT,
        OP_ACC_GAMMA,
        OP_ERR,
        OP_DELTA,
        OP_W_UPD
    } dp_op_t;

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_LOOP_BEH,
        JMP_LOOP_SLOT,
        JMP_CHOOSE,
        JMP_WAIT_OUT
    } jmp_t;

    typedef struct packed {
        rd_sel_t  rd;
        mul_sel_t mul;
        dp_op_t   op;
        jmp_t     jmp;
        step_t    target;
    } ucw_t;

    function automatic ucw_t ucode_rom(input step_t addr);
        ucw_t w;
        w = '{rd: RD_NONE, mul: MUL_NONE, op: OP_NOP, jmp: JMP_NEXT, target: S_RD_F0};
        case (addr)
            S_RD_F0:
            begin
                w.rd = RD_FEAT0;
            end
            S_MUL_F0:
            begin
                w.rd  = RD_FEAT1;
                w.mul = MUL_WF0;
            end
            S_MUL_F1:
            begin
                w.mul = MUL_WF1;
                w.op  = OP_ACC_LOAD;
            end
            S_ACC_SUM:
            begin
                w.rd = RD_CNT;
                w.op = OP_ACC_ADD;
            end
            S_EVAL:
            begin
                w.op = OP_Q_EVAL;
            end
            S_CMP:
            begin
                w.rd     = RD_CNT_INC;
                w.op     = OP_Q_CMP;
                w.jmp    = JMP_LOOP_BEH;
                w.target = S_EVAL;
            end
            S_COMMIT:
            begin
                w.op     = OP_COMMIT;
                w.jmp    = JMP_CHOOSE;
                w.target = S_DONE;
            end
            S_GAMMA:
            begin
                w.mul = MUL_GAMMA;
            end
            S_ACC_G:
            begin
                w.op = OP_ACC_GAMMA;
            end
            S_ERR:
            begin
                w.op = OP_ERR;
            end
            S_ALPHA:
            begin
                w.rd  = RD_CNT;
                w.mul = MUL_ALPHA;
            end
            S_DELTA:
            begin
                w.op = OP_DELTA;
            end
            S_SNAP_MUL:
            begin
                w.mul = MUL_SNAP;
            end
            S_W_UPD:
            begin
                w.rd     = RD_CNT_INC;
                w.op     = OP_W_UPD;
                w.jmp    = JMP_LOOP_SLOT;
                w.target = S_SNAP_MUL;
            end
            S_DONE:
            begin
                w.jmp = JMP_WAIT_OUT;
            end
            default:
            begin
                w.jmp = JMP_WAIT_OUT;
            end
        endcase
        return w;
    endfunction

    // add half an LSB, then floor
    function automatic logic signed [ACC_W-1:0] round_shr(
        input logic signed [ACC_W-1:0] v,
        input int unsigned             sh
    );
        logic signed [ACC_W-1:0] bias;
        bias = ACC_W'(1) << (sh - 1);
        return (v + bias) >>> sh;
    endfunction

    function automatic logic signed [W_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-W_W:0] top;
        top = v[ACC_W-1:W_W-1];
        if (top == '0 || top == '1)
        begin
            return v[W_W-1:0];
        end
        else if (v[ACC_W-1])
        begin
            return Q_MIN;
        end
        else
        begin
            return Q_MAX;
        end
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/linear_q_learning_update.sv */
// Top level of the linear Q-learning update block: microcoded sequencer,
// shared multiplier datapath, weight and feature state, APB register port.
// Depends on lqlu_pkg.
`default_nettype none

// Takes one request word at a time (load features, choose behavior, learn with
// reward) and returns one response word per request: the chosen behavior and
// the latest maximum q value. A load, or an unused request code, runs only the
// final step of the microcode program. In that program every behavior costs
// two steps of q evaluation and compare, and every weight costs two steps of
// the single 32x17 multiplier and the single weight read port. A new request
// is taken while the previous response still waits; the program then holds in
// its last step until the response register is free. learning_rate is at byte
// address 0 and gamma at byte address 4.
module linear_q_learning_update (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  logic [1:0]                         req_type,
    input  logic [lqlu_pkg::FEAT_W-1:0]        feature_ghost,
    input  logic [lqlu_pkg::FEAT_W-1:0]        feature_food,
    input  logic signed [lqlu_pkg::REW_W-1:0]  reward,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output logic [lqlu_pkg::BEH_W-1:0]         chosen_behavior,
    output logic signed [lqlu_pkg::W_W-1:0]    peak_q,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lqlu_pkg::ADDR_W-1:0]        paddr,
    input  logic [lqlu_pkg::DATA_W-1:0]        pwdata,
    output logic [lqlu_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);
    import lqlu_pkg::*;

    logic                     busy_reg;
    logic                     busy_next;
    step_t                    step_reg;
    step_t                    step_next;
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         cnt_next;
    req_type_t                req_reg;
    req_type_t                req_next;
    logic signed [REW_W-1:0]  reward_reg;
    logic signed [REW_W-1:0]  reward_next;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;
    logic [BEH_W-1:0]         rsp_beh_reg;
    logic [BEH_W-1:0]         rsp_beh_next;
    logic signed [W_W-1:0]    rsp_q_reg;
    logic signed [W_W-1:0]    rsp_q_next;

    logic [COEF_W-1:0]        learning_rate_reg;
    logic [COEF_W-1:0]        gamma_reg;

    logic signed [W_W-1:0]    weight_reg [SLOT_COUNT];
    logic [FEAT_W-1:0]        feat_reg [2];
    logic [FEAT_W-1:0]        snap_reg [SLOT_COUNT];
    logic signed [W_W-1:0]    prev_reg;
    logic signed [W_W-1:0]    latest_reg;
    logic [BEH_W-1:0]         behavior_reg;

    logic signed [W_W-1:0]    rd_data_reg;
    logic signed [MUL_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [W_W-1:0]    q_reg;
    logic signed [W_W-1:0]    best_reg;
    logic [BEH_W-1:0]         best_idx_reg;
    logic signed [W_W-1:0]    err_reg;
    logic signed [W_W-1:0]    delta_reg;

    ucw_t                     ucw;
    logic                     req_fire;
    logic                     rsp_free;
    logic                     cfg_write;
    logic [CNT_W-1:0]         rd_addr;
    logic                     rd_in_range;
    logic signed [W_W-1:0]    mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_W-1:0]  mul_full;
    logic signed [ACC_W-1:0]  q_sum;
    logic signed [W_W-1:0]    q_val;
    logic signed [ACC_W-1:0]  gamma_term;
    logic signed [W_W-1:0]    err_val;
    logic signed [ACC_W-1:0]  delta_full;
    logic signed [ACC_W-1:0]  corr;
    logic signed [W_W-1:0]    w_new;

    assign ucw       = ucode_rom(step_reg);
    assign req_ready = !busy_reg;
    assign req_fire  = req_valid && req_ready;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    assign rsp_valid       = rsp_valid_reg;
    assign chosen_behavior = rsp_beh_reg;
    assign peak_q          = rsp_q_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learning_rate_reg <= LEARN_RATE_RST;
            gamma_reg         <= DISCOUNT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(paddr[2]))
                CFG_LEARNING_RATE: learning_rate_reg <= pwdata[COEF_W-1:0];
                CFG_GAMMA:         gamma_reg         <= pwdata[COEF_W-1:0];
                default:           learning_rate_reg <= learning_rate_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_reg_t'(paddr[2]))
            CFG_LEARNING_RATE: prdata = DATA_W'(learning_rate_reg);
            CFG_GAMMA:         prdata = DATA_W'(gamma_reg);
            default:           prdata = '0;
        endcase
    end

    // sequencer: step counter, loop counter, jumps
    always_comb
    begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        cnt_next       = cnt_reg;
        req_next       = req_reg;
        reward_next    = reward_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_beh_next   = rsp_beh_reg;
        rsp_q_next     = rsp_q_reg;
        if (!busy_reg)
        begin
            if (req_valid)
            begin
                busy_next   = 1'b1;
                cnt_next    = '0;
                req_next    = req_type_t'(req_type);
                reward_next = reward;
                if (req_type == REQ_CHOOSE || req_type == REQ_LEARN)
                begin
                    step_next = S_RD_F0;
                end
                else
                begin
                    step_next = S_DONE;
                end
            end
        end
        else
        begin
            case (ucw.jmp)
                JMP_NEXT:
                begin
                    step_next = step_t'(step_reg + 1'b1);
                end
                JMP_LOOP_BEH:
                begin
                    if (cnt_reg == BEH_LAST)
                    begin
                        cnt_next  = '0;
                        step_next = step_t'(step_reg + 1'b1);
                    end
                    else
                    begin
                        cnt_next  = cnt_reg + 1'b1;
                        step_next = ucw.target;
                    end
                end
                JMP_LOOP_SLOT:
                begin
                    if (cnt_reg == SLOT_LAST)
                    begin
                        cnt_next  = '0;
                        step_next = step_t'(step_reg + 1'b1);
                    end
                    else
                    begin
                        cnt_next  = cnt_reg + 1'b1;
                        step_next = ucw.target;
                    end
                end
                JMP_CHOOSE:
                begin
                    if (req_reg == REQ_CHOOSE)
                    begin
                        step_next = ucw.target;
                    end
                    else
                    begin
                        step_next = step_t'(step_reg + 1'b1);
                    end
                end
                JMP_WAIT_OUT:
                begin
                    if (rsp_free)
                    begin
                        busy_next      = 1'b0;
                        rsp_valid_next = 1'b1;
                        rsp_beh_next   = behavior_reg;
                        rsp_q_next     = latest_reg;
                    end
                end
                default:
                begin
                    step_next = S_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= S_DONE;
            cnt_reg       <= '0;
            req_reg       <= REQ_LOAD;
            reward_reg    <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_beh_reg   <= '0;
            rsp_q_reg     <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            req_reg       <= req_next;
            reward_reg    <= reward_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_beh_reg   <= rsp_beh_next;
            rsp_q_reg     <= rsp_q_next;
        end
    end

    // weight read port
    always_comb
    begin
        case (ucw.rd)
            RD_FEAT0:   rd_addr = SLOT_FEAT0;
            RD_FEAT1:   rd_addr = SLOT_FEAT1;
            RD_CNT:     rd_addr = cnt_reg;
            RD_CNT_INC: rd_addr = cnt_reg + 1'b1;
            default:    rd_addr = cnt_reg;
        endcase
    end

    assign rd_in_range = ({1'b0, rd_addr} < (CNT_W + 1)'(SLOT_COUNT));

    // shared multiplier operand select
    always_comb
    begin
        case (ucw.mul)
            MUL_WF0:
            begin
                mul_a = rd_data_reg;
                mul_b = signed'({1'b0, feat_reg[0]});
            end
            MUL_WF1:
            begin
                mul_a = rd_data_reg;
                mul_b = signed'({1'b0, feat_reg[1]});
            end
            MUL_GAMMA:
            begin
                mul_a = latest_reg;
                mul_b = signed'({1'b0, gamma_reg});
            end
            MUL_ALPHA:
            begin
                mul_a = err_reg;
                mul_b = signed'({1'b0, learning_rate_reg});
            end
            MUL_SNAP:
            begin
                mul_a = delta_reg;
                mul_b = signed'({1'b0, snap_reg[cnt_reg]});
            end
            default:
            begin
                mul_a = rd_data_reg;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full   = MUL_W'(mul_a) * MUL_W'(mul_b);
    assign q_sum      = (ACC_W'(rd_data_reg) <<< 15) + acc_reg;
    assign q_val      = sat32(round_shr(q_sum, 15));
    assign gamma_term = round_shr(ACC_W'(prod_reg), 16) + (ACC_W'(reward_reg) <<< 16);
    assign err_val    = sat32(acc_reg - ACC_W'(prev_reg));
    assign delta_full = round_shr(ACC_W'(prod_reg), 16);
    assign corr       = round_shr(ACC_W'(prod_reg), 15);
    assign w_new      = sat32(ACC_W'(rd_data_reg) + corr);

    // datapath working registers
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            if (ucw.rd != RD_NONE)
            begin
                rd_data_reg <= rd_in_range ? weight_reg[rd_addr] : '0;
            end
            if (ucw.mul != MUL_NONE)
            begin
                prod_reg <= mul_full;
            end
            case (ucw.op)
                OP_ACC_LOAD:  acc_reg <= ACC_W'(prod_reg);
                OP_ACC_ADD:   acc_reg <= acc_reg + ACC_W'(prod_reg);
                OP_ACC_GAMMA: acc_reg <= gamma_term;
                OP_Q_EVAL:    q_reg   <= q_val;
                OP_Q_CMP:
                begin
                    if (cnt_reg == '0 || q_reg > best_reg)
                    begin
                        best_reg     <= q_reg;
                        best_idx_reg <= BEH_W'(cnt_reg);
                    end
                end
                OP_ERR:       err_reg   <= err_val;
                OP_DELTA:     delta_reg <= delta_full[W_W-1:0];
                default:      acc_reg   <= acc_reg;
            endcase
        end
    end

    // architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                weight_reg[i] <= '0;
                snap_reg[i]   <= '0;
            end
            feat_reg[0]  <= '0;
            feat_reg[1]  <= '0;
            prev_reg     <= '0;
            latest_reg   <= '0;
            behavior_reg <= '0;
        end
        else
        begin
            if (req_fire && req_type == REQ_LOAD)
            begin
                feat_reg[0] <= feature_ghost;
                feat_reg[1] <= feature_food;
            end
            if (busy_reg)
            begin
                case (ucw.op)
                    OP_COMMIT:
                    begin
                        prev_reg     <= latest_reg;
                        latest_reg   <= best_reg;
                        behavior_reg <= best_idx_reg;
                        if (req_reg == REQ_CHOOSE)
                        begin
                            for (int i = 0; i < BEHAVIOR_COUNT; i++)
                            begin
                                snap_reg[i] <= (BEH_W'(i) == best_idx_reg) ? ONE_Q15 : '0;
                            end
                            snap_reg[SLOT_FEAT0] <= feat_reg[0];
                            snap_reg[SLOT_FEAT1] <= feat_reg[1];
                        end
                    end
                    OP_W_UPD:
                    begin
                        weight_reg[cnt_reg] <= w_new;
                    end
                    default:
                    begin
                        prev_reg <= prev_reg;
                    end
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> ({1'b0, cnt_reg} < (CNT_W + 1)'(SLOT_COUNT)))
        else $error("loop counter out of range");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(busy_reg && step_reg == S_DONE))
        else $error("response raised outside the final step");

    a_load_features: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req_type == REQ_LOAD) |=>
            (feat_reg[0] == $past(feature_ghost) && feat_reg[1] == $past(feature_food)))
        else $error("feature load lost");

    a_update_only_learn: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && ucw.op == OP_W_UPD) |-> (req_reg == REQ_LEARN))
        else $error("weight update outside a learn request");
`endif

endmodule

`default_nettype wire
